// File: rtl/assert_macros.svh
// Assertion macros used by quaternion_arithmetic_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed: implication");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("assertion failed: forbidden condition");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/qau_pkg.sv
`default_nettype none
package qau_pkg;
	localparam int FRAC = 16;
	localparam int MW = 65 - FRAC;
	localparam int DW = (MW > 33) ? MW : 33;
	localparam int SQ_STEPS = 33;
	localparam int DIV_STEPS = 32;

	typedef enum logic [3:0] {
		CMD_ADD  = 4'd0,
		CMD_SUB  = 4'd1,
		CMD_MUL  = 4'd2,
		CMD_SCL  = 4'd3,
		CMD_CONJ = 4'd4,
		CMD_NORM = 4'd5,
		CMD_NRMZ = 4'd6,
		CMD_INV  = 4'd7,
		CMD_DIV  = 4'd8,
		CMD_SDIV = 4'd9
	} cmd_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DIVZ = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	typedef logic [3:0][31:0] quat_t;

	typedef struct packed {
		cmd_t cmd;
		quat_t a;
		quat_t b;
		logic [31:0] s;
		quat_t er;
		logic esat;
		logic [DW-1:0] m;
		logic [32:0] n;
		logic [DW-1:0] dvs;
		logic err;
		logic [3:0] neg;
		logic [3:0] ovf;
		quat_t dq;
		logic dsat;
	} pass_t;

	typedef struct packed {
		logic [65:0] rad;
		logic [34:0] rem;
		logic [32:0] root;
	} sq_t;

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [31:0] nq;
	} dvl_t;

	typedef dvl_t [3:0] dv_t;

	function automatic logic [32:0] sat32(input logic signed [65:0] v);
		logic [32:0] r;
		if (v > 66'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -66'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

	function automatic logic signed [65:0] trunc_q(input logic signed [65:0] x);
		logic [65:0] bias;
		bias = '0;
		if (x[65]) begin
			bias[FRAC-1:0] = '1;
		end
		return (x + $signed(bias)) >>> FRAC;
	endfunction
endpackage
`default_nettype wire

// File: rtl/qau_sqrt_cell.sv
`default_nettype none
module qau_sqrt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  qau_pkg::pass_t  in_p,
	input  qau_pkg::sq_t    in_q,
	output logic            out_vld,
	output qau_pkg::pass_t  out_p,
	output qau_pkg::sq_t    out_q
);
	logic [36:0] cur;
	logic [36:0] trial;
	logic [36:0] diff;
	logic ge;
	qau_pkg::sq_t nxt;
	logic vld_q;
	qau_pkg::pass_t p_q;
	qau_pkg::sq_t q_q;

	always_comb begin
		cur = {in_q.rem, in_q.rad[65:64]};
		trial = {2'b00, in_q.root, 2'b01};
		diff = cur - trial;
		ge = (cur >= trial);
		nxt.rad = {in_q.rad[63:0], 2'b00};
		nxt.rem = ge ? diff[34:0] : cur[34:0];
		nxt.root = {in_q.root[31:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		p_q <= in_p;
		q_q <= nxt;
	end

	assign out_vld = vld_q;
	assign out_p = p_q;
	assign out_q = q_q;
endmodule
`default_nettype wire

// File: rtl/qau_div_cell.sv
`default_nettype none
module qau_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  qau_pkg::pass_t  in_p,
	input  qau_pkg::dv_t    in_d,
	output logic            out_vld,
	output qau_pkg::pass_t  out_p,
	output qau_pkg::dv_t    out_d
);
	logic [qau_pkg::DW:0] sh [4];
	logic [qau_pkg::DW:0] dd;
	logic [qau_pkg::DW:0] sub [4];
	logic [3:0] ge;
	qau_pkg::dv_t nxt;
	logic vld_q;
	qau_pkg::pass_t p_q;
	qau_pkg::dv_t d_q;

	always_comb begin
		dd = {1'b0, in_p.dvs};
		for (int i = 0; i < 4; i++) begin
			sh[i] = {in_d[i].rem, in_d[i].nq[31]};
			sub[i] = sh[i] - dd;
			ge[i] = (sh[i] >= dd);
			nxt[i].rem = ge[i] ? sub[i][qau_pkg::DW-1:0] : sh[i][qau_pkg::DW-1:0];
			nxt[i].nq = {in_d[i].nq[30:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		p_q <= in_p;
		d_q <= nxt;
	end

	assign out_vld = vld_q;
	assign out_p = p_q;
	assign out_d = d_q;
endmodule
`default_nettype wire

// File: rtl/qau_ham.sv
`default_nettype none
module qau_ham (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  qau_pkg::pass_t  in_p,
	output logic            out_vld,
	output qau_pkg::pass_t  out_p,
	output qau_pkg::quat_t  out_r,
	output logic            out_sat
);
	qau_pkg::quat_t bb;
	logic signed [63:0] pr [4][4];
	logic signed [63:0] pr_s1 [4][4];
	logic signed [65:0] sm [4];
	logic signed [65:0] sm_s2 [4];
	logic [32:0] t [4];
	qau_pkg::quat_t r_s3;
	logic sat_s3;
	logic vld_s1, vld_s2, vld_s3;
	qau_pkg::pass_t p_s1, p_s2, p_s3;

	always_comb begin
		bb = (in_p.cmd == qau_pkg::CMD_DIV) ? in_p.dq : in_p.b;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				pr[i][j] = $signed(in_p.a[i]) * $signed(bb[j]);
			end
		end
	end

	always_comb begin
		sm[0] = 66'(pr_s1[0][0]) - 66'(pr_s1[1][1]) - 66'(pr_s1[2][2]) - 66'(pr_s1[3][3]);
		sm[1] = 66'(pr_s1[0][1]) + 66'(pr_s1[1][0]) + 66'(pr_s1[2][3]) - 66'(pr_s1[3][2]);
		sm[2] = 66'(pr_s1[0][2]) - 66'(pr_s1[1][3]) + 66'(pr_s1[2][0]) + 66'(pr_s1[3][1]);
		sm[3] = 66'(pr_s1[0][3]) + 66'(pr_s1[1][2]) - 66'(pr_s1[2][1]) + 66'(pr_s1[3][0]);
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			t[i] = qau_pkg::sat32(qau_pkg::trunc_q(sm_s2[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= in_p;
		p_s2 <= p_s1;
		p_s3 <= p_s2;
		pr_s1 <= pr;
		sm_s2 <= sm;
		for (int i = 0; i < 4; i++) begin
			r_s3[i] <= t[i][31:0];
		end
		sat_s3 <= t[0][32] | t[1][32] | t[2][32] | t[3][32];
	end

	assign out_vld = vld_s3;
	assign out_p = p_s3;
	assign out_r = r_s3;
	assign out_sat = sat_s3;
endmodule
`default_nettype wire

// File: rtl/quaternion_arithmetic_unit.sv
// Channel   Signals                                        Handshake
// command   start, busy, command, a_*, b_*, scale_value    taken when start and not busy
// result    done, r_w, r_x, r_y, r_z, status               one cycle with done, no stall
//
// One word is taken every cycle; busy stays low.
// Each word gives its result in order.
// Every word passes through the 33 square-root cells and the 32 divider cells.
// The asynchronous reset clears every valid bit, so done is low after reset.
// The receiver cannot stall, so nothing is held back inside the pipeline.
`default_nettype none
`include "assert_macros.svh"
module quaternion_arithmetic_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         command,
	input  logic signed [31:0] a_w,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] b_w,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] scale_value,
	output logic               done,
	output logic signed [31:0] r_w,
	output logic signed [31:0] r_x,
	output logic signed [31:0] r_y,
	output logic signed [31:0] r_z,
	output logic [1:0]         status
);
	qau_pkg::pass_t in_p;
	logic vld_s1, vld_s2, vld_s3;
	qau_pkg::pass_t p_s1, p_s2, p_s3;
	qau_pkg::quat_t src;
	logic signed [63:0] sqp [4];
	logic signed [63:0] scp [4];
	logic signed [32:0] ar [4];
	logic signed [63:0] sqp_s2 [4];
	logic signed [63:0] scp_s2 [4];
	logic signed [32:0] ar_s2 [4];
	logic [65:0] ssum;
	logic [32:0] et [4];
	qau_pkg::pass_t p3_d;
	qau_pkg::sq_t q3_d;
	qau_pkg::sq_t q_s3;

	logic sv [0:qau_pkg::SQ_STEPS];
	qau_pkg::pass_t sp [0:qau_pkg::SQ_STEPS];
	qau_pkg::sq_t sqq [0:qau_pkg::SQ_STEPS];

	qau_pkg::pass_t pd;
	qau_pkg::dv_t dd;
	logic [31:0] s_mag;
	logic signed [32:0] num [4];
	logic [32:0] mg [4];
	logic [31:0] hi [4];

	logic dv_vld0_q;
	qau_pkg::pass_t dv_p0_q;
	qau_pkg::dv_t dv_d0_q;
	logic dv_vld [0:qau_pkg::DIV_STEPS];
	qau_pkg::pass_t dv_p [0:qau_pkg::DIV_STEPS];
	qau_pkg::dv_t dv_d [0:qau_pkg::DIV_STEPS];

	qau_pkg::pass_t pf;
	logic [32:0] ft [4];
	logic vld_f;
	qau_pkg::pass_t p_f;

	logic hv;
	qau_pkg::pass_t hp;
	qau_pkg::quat_t hr;
	logic hsat;

	qau_pkg::quat_t ro;
	logic so;
	logic [1:0] sto;
	logic done_q;
	qau_pkg::quat_t r_q;
	logic [1:0] st_q;

	logic nrmz_chk;
	logic divz_out;

	assign busy = 1'b0;

	always_comb begin
		in_p = '0;
		in_p.cmd = qau_pkg::cmd_t'(command);
		in_p.a = {a_z, a_y, a_x, a_w};
		in_p.b = {b_z, b_y, b_x, b_w};
		in_p.s = scale_value;
	end

	always_comb begin
		src = (p_s1.cmd == qau_pkg::CMD_DIV) ? p_s1.b : p_s1.a;
		for (int i = 0; i < 4; i++) begin
			sqp[i] = $signed(src[i]) * $signed(src[i]);
			scp[i] = $signed(p_s1.a[i]) * $signed(p_s1.s);
			case (p_s1.cmd)
				qau_pkg::CMD_ADD: begin
					ar[i] = $signed({p_s1.a[i][31], p_s1.a[i]})
						+ $signed({p_s1.b[i][31], p_s1.b[i]});
				end
				qau_pkg::CMD_SUB: begin
					ar[i] = $signed({p_s1.a[i][31], p_s1.a[i]})
						- $signed({p_s1.b[i][31], p_s1.b[i]});
				end
				qau_pkg::CMD_CONJ: begin
					if (i == 0) begin
						ar[i] = $signed({p_s1.a[i][31], p_s1.a[i]});
					end else begin
						ar[i] = -$signed({p_s1.a[i][31], p_s1.a[i]});
					end
				end
				default: begin
					ar[i] = '0;
				end
			endcase
		end
	end

	always_comb begin
		ssum = 66'(unsigned'(sqp_s2[0])) + 66'(unsigned'(sqp_s2[1]))
			+ 66'(unsigned'(sqp_s2[2])) + 66'(unsigned'(sqp_s2[3]));
		p3_d = p_s2;
		p3_d.esat = 1'b0;
		for (int i = 0; i < 4; i++) begin
			case (p_s2.cmd)
				qau_pkg::CMD_ADD, qau_pkg::CMD_SUB, qau_pkg::CMD_CONJ: begin
					et[i] = qau_pkg::sat32(66'(ar_s2[i]));
				end
				qau_pkg::CMD_SCL: begin
					et[i] = qau_pkg::sat32(qau_pkg::trunc_q(66'(scp_s2[i])));
				end
				default: begin
					et[i] = '0;
				end
			endcase
			p3_d.er[i] = et[i][31:0];
			p3_d.esat = p3_d.esat | et[i][32];
		end
		p3_d.m = qau_pkg::DW'(ssum[64:qau_pkg::FRAC]);
		q3_d.rad = ssum;
		q3_d.rem = '0;
		q3_d.root = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= in_p;
		p_s2 <= p_s1;
		sqp_s2 <= sqp;
		scp_s2 <= scp;
		ar_s2 <= ar;
		p_s3 <= p3_d;
		q_s3 <= q3_d;
	end

	assign sv[0] = vld_s3;
	assign sp[0] = p_s3;
	assign sqq[0] = q_s3;

	for (genvar k = 0; k < qau_pkg::SQ_STEPS; k++) begin : g_sqrt
		qau_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (sv[k]),
			.in_p    (sp[k]),
			.in_q    (sqq[k]),
			.out_vld (sv[k+1]),
			.out_p   (sp[k+1]),
			.out_q   (sqq[k+1])
		);
	end

	always_comb begin
		pd = sp[qau_pkg::SQ_STEPS];
		pd.n = sqq[qau_pkg::SQ_STEPS].root;
		s_mag = pd.s[31] ? (32'd0 - pd.s) : pd.s;
		case (pd.cmd)
			qau_pkg::CMD_NRMZ: pd.dvs = qau_pkg::DW'(pd.n);
			qau_pkg::CMD_INV, qau_pkg::CMD_DIV: pd.dvs = pd.m;
			qau_pkg::CMD_SDIV: pd.dvs = qau_pkg::DW'(s_mag);
			default: pd.dvs = '0;
		endcase
		pd.err = (pd.cmd == qau_pkg::CMD_NRMZ || pd.cmd == qau_pkg::CMD_INV
			|| pd.cmd == qau_pkg::CMD_DIV || pd.cmd == qau_pkg::CMD_SDIV)
			&& (pd.dvs == '0);
		for (int i = 0; i < 4; i++) begin
			case (pd.cmd)
				qau_pkg::CMD_NRMZ, qau_pkg::CMD_SDIV: begin
					num[i] = $signed({pd.a[i][31], pd.a[i]});
				end
				qau_pkg::CMD_INV: begin
					num[i] = (i == 0) ? $signed({pd.a[i][31], pd.a[i]})
						: -$signed({pd.a[i][31], pd.a[i]});
				end
				qau_pkg::CMD_DIV: begin
					num[i] = (i == 0) ? $signed({pd.b[i][31], pd.b[i]})
						: -$signed({pd.b[i][31], pd.b[i]});
				end
				default: begin
					num[i] = '0;
				end
			endcase
			mg[i] = num[i][32] ? unsigned'(-num[i]) : unsigned'(num[i]);
			hi[i] = mg[i][31:0] >> (32 - qau_pkg::FRAC);
			pd.neg[i] = num[i][32] ^ ((pd.cmd == qau_pkg::CMD_SDIV) & pd.s[31]);
			pd.ovf[i] = (qau_pkg::DW'(hi[i]) >= pd.dvs);
			dd[i].rem = qau_pkg::DW'(hi[i]);
			dd[i].nq = mg[i][31:0] << qau_pkg::FRAC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld0_q <= 1'b0;
		end else begin
			dv_vld0_q <= sv[qau_pkg::SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		dv_p0_q <= pd;
		dv_d0_q <= dd;
	end

	assign dv_vld[0] = dv_vld0_q;
	assign dv_p[0] = dv_p0_q;
	assign dv_d[0] = dv_d0_q;

	for (genvar k = 0; k < qau_pkg::DIV_STEPS; k++) begin : g_div
		qau_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (dv_vld[k]),
			.in_p    (dv_p[k]),
			.in_d    (dv_d[k]),
			.out_vld (dv_vld[k+1]),
			.out_p   (dv_p[k+1]),
			.out_d   (dv_d[k+1])
		);
	end

	always_comb begin
		pf = dv_p[qau_pkg::DIV_STEPS];
		pf.dsat = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (pf.ovf[i]) begin
				ft[i] = pf.neg[i] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
			end else if (pf.neg[i]) begin
				ft[i] = qau_pkg::sat32(-$signed({34'b0, dv_d[qau_pkg::DIV_STEPS][i].nq}));
			end else begin
				ft[i] = qau_pkg::sat32($signed({34'b0, dv_d[qau_pkg::DIV_STEPS][i].nq}));
			end
			pf.dq[i] = ft[i][31:0];
			pf.dsat = pf.dsat | ft[i][32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_f <= 1'b0;
		end else begin
			vld_f <= dv_vld[qau_pkg::DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		p_f <= pf;
	end

	qau_ham u_ham (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_f),
		.in_p    (p_f),
		.out_vld (hv),
		.out_p   (hp),
		.out_r   (hr),
		.out_sat (hsat)
	);

	always_comb begin
		ro = '0;
		so = 1'b0;
		case (hp.cmd)
			qau_pkg::CMD_ADD, qau_pkg::CMD_SUB, qau_pkg::CMD_SCL, qau_pkg::CMD_CONJ: begin
				ro = hp.er;
				so = hp.esat;
			end
			qau_pkg::CMD_MUL: begin
				ro = hr;
				so = hsat;
			end
			qau_pkg::CMD_DIV: begin
				ro = hr;
				so = hsat | hp.dsat;
			end
			qau_pkg::CMD_NORM: begin
				so = hp.n[32] | hp.n[31];
				ro[0] = so ? 32'h7FFF_FFFF : hp.n[31:0];
			end
			qau_pkg::CMD_NRMZ, qau_pkg::CMD_INV, qau_pkg::CMD_SDIV: begin
				ro = hp.dq;
				so = hp.dsat;
			end
			default: begin
				ro = '0;
				so = 1'b0;
			end
		endcase
		if (hp.err) begin
			ro = '0;
			sto = qau_pkg::ST_DIVZ;
		end else if (so) begin
			sto = qau_pkg::ST_SAT;
		end else begin
			sto = qau_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= hv;
		end
	end

	always_ff @(posedge clk) begin
		r_q <= ro;
		st_q <= sto;
	end

	assign done = done_q;
	assign r_w = $signed(r_q[0]);
	assign r_x = $signed(r_q[1]);
	assign r_y = $signed(r_q[2]);
	assign r_z = $signed(r_q[3]);
	assign status = st_q;

	assign nrmz_chk = dv_vld[0] && dv_p[0].cmd == qau_pkg::CMD_NRMZ && !dv_p[0].err;
	assign divz_out = done && status == qau_pkg::ST_DIVZ;

	`ASSERT_IMPLIES(a_nrmz_no_ovf, clk, arst_n, nrmz_chk, dv_p[0].ovf == 4'b0000)
	`ASSERT_NEVER(a_divz_zero, clk, arst_n, divz_out && r_q != '0)
endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [127:0] wide_t;
	typedef logic signed [31:0] q4_t [4];

	typedef struct {
		logic [3:0] cmd;
		q4_t a;
		q4_t b;
		logic signed [31:0] s;
	} word_t;

	typedef struct {
		q4_t r;
		logic [1:0] st;
	} result_t;

	localparam logic [3:0] CMD_UNKNOWN = 4'd15;
	localparam wide_t ONE = 128'sd65536;
	localparam int MAX_POS = 32'h7FFF_FFFF;
	localparam int MAX_NEG = 32'h8000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [3:0] command = '0;
	logic signed [31:0] a_w = '0, a_x = '0, a_y = '0, a_z = '0;
	logic signed [31:0] b_w = '0, b_x = '0, b_y = '0, b_z = '0;
	logic signed [31:0] scale_value = '0;
	logic done;
	logic signed [31:0] r_w, r_x, r_y, r_z;
	logic [1:0] status;

	word_t pending_words[$];
	result_t expected_results[$];
	int mismatches = 0;
	int gap = 0;
	int words_sent = 0;
	bit burst = 1'b0;
	word_t cur;

	quaternion_arithmetic_unit DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .command(command),
		.a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z),
		.scale_value(scale_value), .done(done),
		.r_w(r_w), .r_x(r_x), .r_y(r_y), .r_z(r_z), .status(status)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic signed [31:0] clamp(input wide_t v, inout bit sat);
		if (v > wide_t'(MAX_POS)) begin
			sat = 1'b1;
			return MAX_POS;
		end
		if (v < wide_t'(MAX_NEG)) begin
			sat = 1'b1;
			return MAX_NEG;
		end
		return v[31:0];
	endfunction

	function automatic wide_t int_sqrt(input wide_t v);
		logic [127:0] s, res, bitv;
		s = v;
		res = '0;
		bitv = 128'd1 << 66;
		while (bitv > s) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s = s - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic wide_t square_sum(input q4_t q);
		wide_t acc, c;
		acc = 0;
		for (int i = 0; i < 4; i++) begin
			c = q[i];
			acc = acc + c * c;
		end
		return acc;
	endfunction

	function automatic void hamilton(input q4_t a, input q4_t b, output q4_t r, inout bit sat);
		wide_t p[4], q[4];
		for (int i = 0; i < 4; i++) begin
			p[i] = a[i];
			q[i] = b[i];
		end
		r[0] = clamp((p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3]) / ONE, sat);
		r[1] = clamp((p[0]*q[1] + p[1]*q[0] + p[2]*q[3] - p[3]*q[2]) / ONE, sat);
		r[2] = clamp((p[0]*q[2] - p[1]*q[3] + p[2]*q[0] + p[3]*q[1]) / ONE, sat);
		r[3] = clamp((p[0]*q[3] + p[1]*q[2] - p[2]*q[1] + p[3]*q[0]) / ONE, sat);
	endfunction

	// Returns 1 when the squared norm truncates to zero.
	function automatic bit inverse_of(input q4_t a, output q4_t r, inout bit sat);
		wide_t m, c;
		m = square_sum(a) >>> 16;
		for (int i = 0; i < 4; i++) r[i] = '0;
		if (m == 0) return 1'b1;
		for (int i = 0; i < 4; i++) begin
			c = a[i];
			if (i != 0) c = -c;
			r[i] = clamp(c * ONE / m, sat);
		end
		return 1'b0;
	endfunction

	function automatic result_t compute_result(input word_t w);
		result_t e;
		bit sat, err;
		wide_t n, c, sc;
		q4_t t;
		sat = 1'b0;
		err = 1'b0;
		sc = w.s;
		for (int i = 0; i < 4; i++) e.r[i] = '0;
		case (w.cmd)
			qau_pkg::CMD_ADD: for (int i = 0; i < 4; i++)
				e.r[i] = clamp(wide_t'(w.a[i]) + w.b[i], sat);
			qau_pkg::CMD_SUB: for (int i = 0; i < 4; i++)
				e.r[i] = clamp(wide_t'(w.a[i]) - w.b[i], sat);
			qau_pkg::CMD_MUL: hamilton(w.a, w.b, e.r, sat);
			qau_pkg::CMD_SCL: for (int i = 0; i < 4; i++)
				e.r[i] = clamp(wide_t'(w.a[i]) * sc / ONE, sat);
			qau_pkg::CMD_CONJ: begin
				e.r[0] = w.a[0];
				for (int i = 1; i < 4; i++) e.r[i] = clamp(-wide_t'(w.a[i]), sat);
			end
			qau_pkg::CMD_NORM: e.r[0] = clamp(int_sqrt(square_sum(w.a)), sat);
			qau_pkg::CMD_NRMZ: begin
				n = int_sqrt(square_sum(w.a));
				if (n == 0) err = 1'b1;
				else for (int i = 0; i < 4; i++) begin
					c = w.a[i];
					e.r[i] = clamp(c * ONE / n, sat);
				end
			end
			qau_pkg::CMD_INV: err = inverse_of(w.a, e.r, sat);
			qau_pkg::CMD_DIV: begin
				err = inverse_of(w.b, t, sat);
				if (!err) hamilton(w.a, t, e.r, sat);
			end
			qau_pkg::CMD_SDIV: begin
				if (sc == 0) err = 1'b1;
				else for (int i = 0; i < 4; i++) begin
					c = w.a[i];
					e.r[i] = clamp(c * ONE / sc, sat);
				end
			end
			default: ;
		endcase
		if (err) for (int i = 0; i < 4; i++) e.r[i] = '0;
		e.st = err ? qau_pkg::ST_DIVZ : (sat ? qau_pkg::ST_SAT : qau_pkg::ST_OK);
		return e;
	endfunction

	task automatic queue_word(input logic [3:0] c, input int aw, input int ax, input int ay,
			input int az, input int bw, input int bx, input int by, input int bz, input int s);
		word_t w;
		w.cmd = c;
		w.a = '{aw, ax, ay, az};
		w.b = '{bw, bx, by, bz};
		w.s = s;
		pending_words.push_back(w);
	endtask

	function automatic int rand_value();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? MAX_POS : MAX_NEG;
			2: return int'($urandom_range(0, 6)) - 3;
			3: return int'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
			default: return int'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(compute_result(cur));
				words_sent++;
				if (words_sent % 150 == 0) burst = ~burst;
				gap = burst ? 0 : $urandom_range(0, 19);
			end
			if (!start || !busy) begin
				if (gap > 0) begin
					gap--;
					start <= 1'b0;
				end else if (pending_words.size() > 0) begin
					cur = pending_words.pop_front();
					command <= cur.cmd;
					a_w <= cur.a[0];
					a_x <= cur.a[1];
					a_y <= cur.a[2];
					a_z <= cur.a[3];
					b_w <= cur.b[0];
					b_x <= cur.b[1];
					b_y <= cur.b[2];
					b_z <= cur.b[3];
					scale_value <= cur.s;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h %h %h %h status %0d",
					r_w, r_x, r_y, r_z, status);
			end else begin
				e = expected_results.pop_front();
				if (r_w !== e.r[0] || r_x !== e.r[1] || r_y !== e.r[2] || r_z !== e.r[3]
						|| status !== e.st) begin
					mismatches++;
					if (mismatches <= 10) $display(
						"mismatch: expected %h %h %h %h status %0d, got %h %h %h %h status %0d",
						e.r[0], e.r[1], e.r[2], e.r[3], e.st, r_w, r_x, r_y, r_z, status);
				end
			end
		end
	end

	initial begin
		queue_word(qau_pkg::CMD_ADD, MAX_POS, MAX_NEG, 1, -1, 1, -1, MAX_POS, MAX_NEG, 0);
		queue_word(qau_pkg::CMD_SUB, MAX_NEG, MAX_POS, 0, 5, 1, -1, MAX_NEG, 3, 0);
		queue_word(qau_pkg::CMD_MUL, 65536, 131072, -65536, 3, 65536, -7, 196608, 65536, 0);
		queue_word(qau_pkg::CMD_MUL, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_POS,
			MAX_NEG, MAX_POS, 0);
		queue_word(qau_pkg::CMD_MUL, -3, 5, -1, 1, 1, -1, 7, -2, 0);
		queue_word(qau_pkg::CMD_SCL, MAX_POS, MAX_NEG, -5, 5, 0, 0, 0, 0, MAX_NEG);
		queue_word(qau_pkg::CMD_SCL, 12345, -12345, 3, -3, 0, 0, 0, 0, 32768);
		queue_word(qau_pkg::CMD_CONJ, MAX_NEG, MAX_NEG, MAX_POS, 0, 0, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_NORM, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, 0, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_NORM, 196608, 262144, 0, 0, 0, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_NORM, MAX_NEG, MAX_NEG, 0, 0, 0, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_NRMZ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_NRMZ, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_NRMZ, MAX_POS, -3, 65536, MAX_NEG, 0, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_INV, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_INV, 100, -100, 50, 7, 0, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_INV, 256, 1, 0, 0, 0, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_INV, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, 0, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_DIV, 65536, 2, 3, 4, 0, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_DIV, MAX_POS, MAX_NEG, 7, -7, 256, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_DIV, 65536, 65536, 0, 65536, 131072, -65536, 65536, 0, 0);
		queue_word(qau_pkg::CMD_SDIV, 65536, -65536, MAX_POS, MAX_NEG, 0, 0, 0, 0, 0);
		queue_word(qau_pkg::CMD_SDIV, MAX_POS, MAX_NEG, 65536, -1, 0, 0, 0, 0, 1);
		queue_word(qau_pkg::CMD_SDIV, 7, -7, 65536, 3, 0, 0, 0, 0, -131072);
		queue_word(CMD_UNKNOWN, MAX_POS, 1, 2, 3, 4, 5, 6, 7, 8);
		repeat (1400) begin
			queue_word($urandom_range(0, 19) == 0 ? 4'($urandom_range(10, 15))
				: 4'($urandom_range(0, 9)), rand_value(), rand_value(), rand_value(),
				rand_value(), rand_value(), rand_value(), rand_value(), rand_value(),
				rand_value());
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_words.size() == 0 && !start && expected_results.size() == 0);
		repeat (120) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("testbench NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
